// ===== hw/rtl/rgb_ycbcr_color_convert_top_macros.svh =====
// Assertion macros shared by the color converter RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef RGB_YCBCR_COLOR_CONVERT_TOP_MACROS_SVH
`define RGB_YCBCR_COLOR_CONVERT_TOP_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define RYC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("color converter check failed");

// Condition in one cycle implies a condition in the next.
`define RYC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  `RYC_ASSERT(lbl, clk, rstn, (ante) |=> (cons))

`endif

// ===== hw/rtl/rgbycc_pkg.sv =====
// Shared constants, types and coefficient table for the color converter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rgbycc_pkg;

  localparam int COEF_FRAC_BITS = 10;
  localparam int PIX_W  = 8;
  localparam int OP_W   = PIX_W + 1;
  // Largest coefficient is below 4.0: two integer bits plus sign.
  localparam int COEF_W = COEF_FRAC_BITS + 3;
  localparam int PROD_W = COEF_W + OP_W;
  localparam int ACC_W  = PROD_W + 2;

  localparam int ONE  = 1 << COEF_FRAC_BITS;
  localparam int HALF = 1 << (COEF_FRAC_BITS - 1);

  localparam int C_257  = ((257  << COEF_FRAC_BITS) + 500) / 1000;
  localparam int C_504  = ((504  << COEF_FRAC_BITS) + 500) / 1000;
  localparam int C_098  = ((98   << COEF_FRAC_BITS) + 500) / 1000;
  localparam int C_439  = ((439  << COEF_FRAC_BITS) + 500) / 1000;
  localparam int C_368  = ((368  << COEF_FRAC_BITS) + 500) / 1000;
  localparam int C_071  = ((71   << COEF_FRAC_BITS) + 500) / 1000;
  localparam int C_148  = ((148  << COEF_FRAC_BITS) + 500) / 1000;
  localparam int C_291  = ((291  << COEF_FRAC_BITS) + 500) / 1000;
  localparam int C_1164 = ((1164 << COEF_FRAC_BITS) + 500) / 1000;
  localparam int C_1596 = ((1596 << COEF_FRAC_BITS) + 500) / 1000;
  localparam int C_813  = ((813  << COEF_FRAC_BITS) + 500) / 1000;
  localparam int C_391  = ((391  << COEF_FRAC_BITS) + 500) / 1000;
  localparam int C_2018 = ((2018 << COEF_FRAC_BITS) + 500) / 1000;

  localparam logic DIR_FWD = 1'b0;
  localparam logic DIR_INV = 1'b1;

  localparam logic [1:0] ROW_A = 2'd0;
  localparam logic [1:0] ROW_B = 2'd1;
  localparam logic [1:0] ROW_C = 2'd2;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [OP_W-1:0]   op_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  // One output row: three weights and the offset with rounding half folded in.
  typedef struct packed {
    coef_t k0;
    coef_t k1;
    coef_t k2;
    acc_t  ofs;
  } row_coef_t;

  function automatic row_coef_t row_coef(input logic dir, input logic [1:0] row);
    row_coef_t rc;
    rc = '0;
    if (dir == DIR_FWD) begin
      case (row)
        ROW_A: begin
          rc.k0  = coef_t'(C_257);
          rc.k1  = coef_t'(C_504);
          rc.k2  = coef_t'(C_098);
          rc.ofs = acc_t'(16 * ONE + HALF);
        end
        ROW_B: begin
          rc.k0  = coef_t'(-C_148);
          rc.k1  = coef_t'(-C_291);
          rc.k2  = coef_t'(C_439);
          rc.ofs = acc_t'(128 * ONE + HALF);
        end
        ROW_C: begin
          rc.k0  = coef_t'(C_439);
          rc.k1  = coef_t'(-C_368);
          rc.k2  = coef_t'(-C_071);
          rc.ofs = acc_t'(128 * ONE + HALF);
        end
        default: rc = '0;
      endcase
    end else begin
      case (row)
        ROW_A: begin
          rc.k0  = coef_t'(C_1164);
          rc.k1  = coef_t'(0);
          rc.k2  = coef_t'(C_1596);
          rc.ofs = acc_t'(HALF);
        end
        ROW_B: begin
          rc.k0  = coef_t'(C_1164);
          rc.k1  = coef_t'(-C_391);
          rc.k2  = coef_t'(-C_813);
          rc.ofs = acc_t'(HALF);
        end
        ROW_C: begin
          rc.k0  = coef_t'(C_1164);
          rc.k1  = coef_t'(C_2018);
          rc.k2  = coef_t'(0);
          rc.ofs = acc_t'(HALF);
        end
        default: rc = '0;
      endcase
    end
    return rc;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rgbycc_dot_row.sv =====
// One output channel: multiply, sum with offset, round and saturate.
// Three register stages; depends on rgbycc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_ycbcr_color_convert_top_macros.svh"

module rgbycc_dot_row (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             valid_i,
  input  wire rgbycc_pkg::row_coef_t            coef_i,
  input  wire rgbycc_pkg::op_t                  op_a_i,
  input  wire rgbycc_pkg::op_t                  op_b_i,
  input  wire rgbycc_pkg::op_t                  op_c_i,
  output logic                                  valid_o,
  output logic [rgbycc_pkg::PIX_W-1:0]          res_o
);

  localparam int SH_W = rgbycc_pkg::ACC_W - rgbycc_pkg::COEF_FRAC_BITS;

  logic signed [rgbycc_pkg::PROD_W-1:0] p0_d, p1_d, p2_d;
  logic signed [rgbycc_pkg::PROD_W-1:0] p0_q, p1_q, p2_q;
  rgbycc_pkg::acc_t                     ofs_q;
  rgbycc_pkg::acc_t                     acc_d, acc_q;
  logic [SH_W-1:0]                      sh;
  logic [rgbycc_pkg::PIX_W-1:0]         res_d, res_q;
  logic                                 s2_valid_q, s3_valid_q, s4_valid_q;

  // Stage 2: products
  assign p0_d = rgbycc_pkg::PROD_W'(coef_i.k0) * rgbycc_pkg::PROD_W'(op_a_i);
  assign p1_d = rgbycc_pkg::PROD_W'(coef_i.k1) * rgbycc_pkg::PROD_W'(op_b_i);
  assign p2_d = rgbycc_pkg::PROD_W'(coef_i.k2) * rgbycc_pkg::PROD_W'(op_c_i);

  // Stage 3: sum
  assign acc_d = rgbycc_pkg::acc_t'(p0_q) + rgbycc_pkg::acc_t'(p1_q)
               + rgbycc_pkg::acc_t'(p2_q) + ofs_q;

  // Stage 4: drop fraction, clamp to pixel range
  assign sh = acc_q[rgbycc_pkg::ACC_W-1:rgbycc_pkg::COEF_FRAC_BITS];
  always_comb begin
    if (acc_q[rgbycc_pkg::ACC_W-1]) begin
      res_d = '0;
    end else if (|sh[SH_W-2:rgbycc_pkg::PIX_W]) begin
      res_d = '1;
    end else begin
      res_d = sh[rgbycc_pkg::PIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= valid_i;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p0_q  <= p0_d;
    p1_q  <= p1_d;
    p2_q  <= p2_d;
    ofs_q <= coef_i.ofs;
    acc_q <= acc_d;
    res_q <= res_d;
  end

  assign valid_o = s4_valid_q;
  assign res_o   = res_q;

  `RYC_ASSERT(a_row_latency, clk_i, rst_ni, valid_i |-> ##3 valid_o)
  `RYC_ASSERT(a_row_no_extra, clk_i, rst_ni, !valid_i |-> ##3 !valid_o)
  `RYC_ASSERT_NEXT(a_row_clamp_low, clk_i, rst_ni,
    s3_valid_q && acc_q[rgbycc_pkg::ACC_W-1], res_q == '0)

endmodule

`default_nettype wire

// ===== hw/rtl/rgb_ycbcr_color_convert_top.sv =====
// Top level of the BT.601 studio-range RGB <-> YCbCr converter.
// Depends on rgbycc_pkg, rgbycc_dot_row and the assertion macro header.
//
//  channel   direction  handshake                      payload
//  pixel in  in         start / busy                   in_a_i, in_b_i, in_c_i
//  result    out        out_valid_o strobe, 1 cycle    out_a_o, out_b_o, out_c_o
//  config    in/out     APB psel/penable/pwrite/pready direction at 0x0
//
// One pixel per clock; busy stays low, so a transfer can start every cycle.
// The pipeline stages are operand/coefficient select, multiply, sum and clamp.
// The three channels run in parallel rows, each with one 13x9 multiplier per term.
// Reset clears the direction register and all stage valid bits.
// The result is shown for one cycle; the receiver cannot stall it.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_ycbcr_color_convert_top_macros.svh"

module rgb_ycbcr_color_convert_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [rgbycc_pkg::PIX_W-1:0] in_a_i,
  input  wire logic [rgbycc_pkg::PIX_W-1:0] in_b_i,
  input  wire logic [rgbycc_pkg::PIX_W-1:0] in_c_i,
  output logic                           out_valid_o,
  output logic [rgbycc_pkg::PIX_W-1:0]   out_a_o,
  output logic [rgbycc_pkg::PIX_W-1:0]   out_b_o,
  output logic [rgbycc_pkg::PIX_W-1:0]   out_c_o,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [2:0]                paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam logic REG_DIRECTION = 1'b0;

  logic                  dir_q, dir_d;
  logic                  cfg_wr;
  logic                  accept;
  logic                  s1_valid_q;
  rgbycc_pkg::op_t       op_a_d, op_b_d, op_c_d;
  rgbycc_pkg::op_t       op_a_q, op_b_q, op_c_q;
  rgbycc_pkg::row_coef_t coef_q [3];
  logic [2:0]            row_valid;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start && !busy;

  // Word index is paddr[2]; only index zero holds a register.
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_DIRECTION);
  assign dir_d  = cfg_wr ? pwdata[0] : dir_q;
  assign prdata = (paddr[2] == REG_DIRECTION) ? {31'd0, dir_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q      <= rgbycc_pkg::DIR_FWD;
      s1_valid_q <= 1'b0;
    end else begin
      dir_q      <= dir_d;
      s1_valid_q <= accept;
    end
  end

  // Stage 1: remove studio offsets in the inverse direction
  always_comb begin
    if (dir_q == rgbycc_pkg::DIR_INV) begin
      op_a_d = rgbycc_pkg::op_t'({1'b0, in_a_i}) - rgbycc_pkg::op_t'(16);
      op_b_d = rgbycc_pkg::op_t'({1'b0, in_b_i}) - rgbycc_pkg::op_t'(128);
      op_c_d = rgbycc_pkg::op_t'({1'b0, in_c_i}) - rgbycc_pkg::op_t'(128);
    end else begin
      op_a_d = rgbycc_pkg::op_t'({1'b0, in_a_i});
      op_b_d = rgbycc_pkg::op_t'({1'b0, in_b_i});
      op_c_d = rgbycc_pkg::op_t'({1'b0, in_c_i});
    end
  end

  always_ff @(posedge clk_i) begin
    op_a_q    <= op_a_d;
    op_b_q    <= op_b_d;
    op_c_q    <= op_c_d;
    coef_q[0] <= rgbycc_pkg::row_coef(dir_q, rgbycc_pkg::ROW_A);
    coef_q[1] <= rgbycc_pkg::row_coef(dir_q, rgbycc_pkg::ROW_B);
    coef_q[2] <= rgbycc_pkg::row_coef(dir_q, rgbycc_pkg::ROW_C);
  end

  rgbycc_dot_row u_row_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid_q),
    .coef_i  (coef_q[0]),
    .op_a_i  (op_a_q),
    .op_b_i  (op_b_q),
    .op_c_i  (op_c_q),
    .valid_o (row_valid[0]),
    .res_o   (out_a_o)
  );

  rgbycc_dot_row u_row_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid_q),
    .coef_i  (coef_q[1]),
    .op_a_i  (op_a_q),
    .op_b_i  (op_b_q),
    .op_c_i  (op_c_q),
    .valid_o (row_valid[1]),
    .res_o   (out_b_o)
  );

  rgbycc_dot_row u_row_c (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid_q),
    .coef_i  (coef_q[2]),
    .op_a_i  (op_a_q),
    .op_b_i  (op_b_q),
    .op_c_i  (op_c_q),
    .valid_o (row_valid[2]),
    .res_o   (out_c_o)
  );

  assign out_valid_o = row_valid[0];

  `RYC_ASSERT(a_rows_aligned, clk_i, rst_ni,
    (row_valid[0] == row_valid[1]) && (row_valid[0] == row_valid[2]))
  `RYC_ASSERT(a_latency, clk_i, rst_ni, accept |-> ##4 out_valid_o)
  `RYC_ASSERT_NEXT(a_dir_write, clk_i, rst_ni, cfg_wr, dir_q == $past(pwdata[0]))

endmodule

`default_nettype wire
